// ===== rtl/core/lag_pkg.sv =====
// Package for the life automaton grid engine: operation and state codes,
// channel widths, register indexes and reset values. Depends on nothing.

package lag_pkg;

    // grid size defaults
    localparam int unsigned DEF_MAX_ROWS = 128;
    localparam int unsigned DEF_MAX_COLS = 128;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ACTIVE_ROWS_RST = 8'd100;
    localparam logic [CFG_DATA_W-1:0] ACTIVE_COLS_RST = 8'd125;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CROW_W  = 7;
    localparam int unsigned CCOL_W  = 7;

    // stream words, padded to whole bytes
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 8;

    // B3/S23
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_TOGGLE  = 2'd1,
        OP_READ    = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_UPDATE,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESP
    } state_t;

    // one column of the 3x3 neighbourhood window, old generation
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } col_t;

endpackage

// ===== rtl/core/lag_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; used for the cell grid and the old-row line buffer.

module lag_ram #(
    parameter int unsigned DATA_W = 1,
    parameter int unsigned ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lag_rule.sv =====
// Neighbour counter and B3/S23 rule for one cell, fed by a 3x3 window.
// Depends on lag_pkg.

module lag_rule (
    input  lag_pkg::col_t win_left,
    input  lag_pkg::col_t win_mid,
    input  lag_pkg::col_t win_right,
    output logic          next_alive
);
    import lag_pkg::*;

    logic [3:0] count;

    always_comb begin
        count = 4'(win_left.top) + 4'(win_left.mid) + 4'(win_left.bot)
              + 4'(win_mid.top)                     + 4'(win_mid.bot)
              + 4'(win_right.top) + 4'(win_right.mid) + 4'(win_right.bot);
        next_alive = (count == BIRTH_COUNT) || (win_mid.mid && (count == SURVIVE_COUNT));
    end

endmodule

// ===== rtl/core/life_automaton_grid_engine.sv =====
// Top level of the life automaton grid engine: sequencer, cell grid RAM,
// old-row line buffer and the shared rule unit. Depends on lag_pkg, lag_ram, lag_rule.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  s_      | in        | s_tvalid/s_tready | operation, cell_row, cell_col, write_value
//  m_      | out       | m_tvalid/m_tready | cell_value, out_of_range
//  cfg_    | in        | cfg_we            | cfg_index, cfg_wdata
//
// Write, toggle and read pass the access and update states; out-of-range accesses go
// straight to the result. Advance sweeps (R+1)*(C+1) positions for R active rows and C
// active columns, one cell per cycle through the grid RAM, then drains; the extra row
// primes the line buffer. After reset, with s_tready low and cfg_ writes taken, a
// clearing pass zeroes 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) words (16384 by default).
// One word is in flight at a time: s_tready is low until the result word is taken.

module life_automaton_grid_engine #(
    parameter int unsigned MAX_ROWS = lag_pkg::DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = lag_pkg::DEF_MAX_COLS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // [1:0] operation, [8:2] cell_row, [15:9] cell_col, [16] write_value, rest zero
    input  logic [lag_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] cell_value, [1] out_of_range, rest zero
    output logic [lag_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [lag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lag_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lag_pkg::*;

    localparam int unsigned RIW    = $clog2(MAX_ROWS);
    localparam int unsigned CIW    = $clog2(MAX_COLS);
    localparam int unsigned GAW    = RIW + CIW;
    localparam int unsigned ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int unsigned COL_CW = $clog2(MAX_COLS + 1);

    // configuration
    logic [CFG_DATA_W-1:0] active_rows_reg;
    logic [CFG_DATA_W-1:0] active_cols_reg;
    logic [ROW_CW-1:0]     eff_rows;
    logic [COL_CW-1:0]     eff_cols;

    // sequencer
    state_t            state_reg, state_next;
    logic [GAW-1:0]    clr_cnt_reg;
    logic [ROW_CW-1:0] nrow_reg;
    logic [COL_CW-1:0] k_reg;
    op_t               op_reg;
    logic [CROW_W-1:0] row_reg;
    logic [CCOL_W-1:0] col_reg;
    logic              wv_reg;
    logic              value_reg;
    logic              oor_reg;

    // sweep second stage
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_colok_reg;
    logic              s1_below_ok_reg;
    logic              s1_above_ok_reg;
    logic              s1_write_reg;
    logic [RIW-1:0]    s1_row_reg;
    logic [CIW-1:0]    s1_col_reg;
    logic [CIW-1:0]    s1_kaddr_reg;
    col_t              win_left_reg;
    col_t              win_mid_reg;
    col_t              win_right;
    logic              rule_out;

    // input fields
    op_t               in_op;
    logic [CROW_W-1:0] in_row;
    logic [CCOL_W-1:0] in_col;
    logic              in_wv;
    logic              in_accept;
    logic              in_oor;
    logic              zero_size;

    // memories
    logic              grid_we;
    logic [GAW-1:0]    grid_waddr;
    logic              grid_wdata;
    logic [GAW-1:0]    grid_raddr;
    logic              grid_rdata;
    logic              lbuf_we;
    logic [CIW-1:0]    lbuf_waddr;
    logic [1:0]        lbuf_wdata;
    logic [CIW-1:0]    lbuf_raddr;
    logic [1:0]        lbuf_rdata;
    logic              upd_value;

    assign in_op  = op_t'(s_tdata[1:0]);
    assign in_row = s_tdata[8:2];
    assign in_col = s_tdata[15:9];
    assign in_wv  = s_tdata[16];

    assign eff_rows = (32'(active_rows_reg) > MAX_ROWS) ? ROW_CW'(MAX_ROWS)
                                                        : ROW_CW'(active_rows_reg);
    assign eff_cols = (32'(active_cols_reg) > MAX_COLS) ? COL_CW'(MAX_COLS)
                                                        : COL_CW'(active_cols_reg);

    assign zero_size = (eff_rows == '0) || (eff_cols == '0);
    assign in_oor    = (32'(in_row) >= 32'(eff_rows)) || (32'(in_col) >= 32'(eff_cols));
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rows_reg <= ACTIVE_ROWS_RST;
            active_cols_reg <= ACTIVE_COLS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ACTIVE_ROWS: active_rows_reg <= cfg_wdata;
                REG_ACTIVE_COLS: active_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_ADVANCE) begin
                        state_next = zero_size ? ST_RESP : ST_SWEEP;
                    end else begin
                        state_next = in_oor ? ST_RESP : ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESP;
            ST_SWEEP: begin
                if ((k_reg == eff_cols) && (nrow_reg == eff_rows)) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_RESP;
            ST_RESP: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // column arriving from the RAMs, with dead cells outside the active grid
    assign win_right.top = lbuf_rdata[1] & s1_colok_reg & s1_above_ok_reg;
    assign win_right.mid = lbuf_rdata[0] & s1_colok_reg;
    assign win_right.bot = grid_rdata & s1_colok_reg & s1_below_ok_reg;

    always_comb begin
        unique case (op_reg)
            OP_WRITE:  upd_value = wv_reg;
            OP_TOGGLE: upd_value = ~grid_rdata;
            default:   upd_value = grid_rdata;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        grid_we    = 1'b0;
        grid_waddr = {RIW'(row_reg), CIW'(col_reg)};
        grid_wdata = upd_value;
        grid_raddr = {RIW'(row_reg), CIW'(col_reg)};
        lbuf_raddr = CIW'(k_reg);
        // old row moves up, next old row goes in below
        lbuf_we    = s1_valid_reg && s1_colok_reg;
        lbuf_waddr = s1_kaddr_reg;
        lbuf_wdata = {lbuf_rdata[0], win_right.bot};
        unique case (state_reg)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_cnt_reg;
                grid_wdata = 1'b0;
            end
            ST_IDLE:   s_tready = 1'b1;
            ST_UPDATE: grid_we = (op_reg != OP_READ);
            ST_SWEEP:  grid_raddr = {nrow_reg[RIW-1:0], CIW'(k_reg)};
            ST_RESP:   m_tvalid = 1'b1;
            default: ;
        endcase
        if (s1_valid_reg) begin
            grid_we    = s1_write_reg;
            grid_waddr = {s1_row_reg, s1_col_reg};
            grid_wdata = rule_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == ST_SWEEP);
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // sweep counters and captured fields
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg    <= in_op;
            row_reg   <= in_row;
            col_reg   <= in_col;
            wv_reg    <= in_wv;
            nrow_reg  <= '0;
            k_reg     <= '0;
            value_reg <= 1'b0;
            oor_reg   <= (in_op != OP_ADVANCE) && in_oor;
        end
        if (state_reg == ST_UPDATE) value_reg <= upd_value;
        if (state_reg == ST_SWEEP) begin
            if (k_reg == eff_cols) begin
                k_reg    <= '0;
                nrow_reg <= nrow_reg + 1'b1;
            end else begin
                k_reg <= k_reg + 1'b1;
            end
        end
        s1_first_reg    <= (k_reg == '0);
        s1_colok_reg    <= (k_reg != eff_cols);
        s1_below_ok_reg <= (nrow_reg != eff_rows);
        s1_above_ok_reg <= (nrow_reg > ROW_CW'(1));
        s1_write_reg    <= (nrow_reg != '0) && (k_reg != '0);
        s1_row_reg      <= RIW'(nrow_reg - 1'b1);
        s1_col_reg      <= CIW'(k_reg - 1'b1);
        s1_kaddr_reg    <= CIW'(k_reg);
        if (s1_valid_reg) begin
            win_left_reg <= s1_first_reg ? col_t'('0) : win_mid_reg;
            win_mid_reg  <= win_right;
        end
    end

    lag_ram #(
        .DATA_W (1),
        .ADDR_W (GAW)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (grid_we),
        .wr_addr (grid_waddr),
        .wr_data (grid_wdata),
        .rd_addr (grid_raddr),
        .rd_data (grid_rdata)
    );

    // bit 1: old row above, bit 0: old row being rewritten
    lag_ram #(
        .DATA_W (2),
        .ADDR_W (CIW)
    ) u_lbuf (
        .aclk    (aclk),
        .wr_en   (lbuf_we),
        .wr_addr (lbuf_waddr),
        .wr_data (lbuf_wdata),
        .rd_addr (lbuf_raddr),
        .rd_data (lbuf_rdata)
    );

    lag_rule u_rule (
        .win_left   (win_left_reg),
        .win_mid    (win_mid_reg),
        .win_right  (win_right),
        .next_alive (rule_out)
    );

    assign m_tdata = {{(M_TDATA_W - 2){1'b0}}, oor_reg, value_reg};

endmodule

// ===== rtl/core/lag_port_checker.sv =====
// Port-level checks for the life automaton grid engine, bound to the top level.
// Depends on lag_pkg and life_automaton_grid_engine.

module lag_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lag_pkg::M_TDATA_W-1:0] m_tdata
);
    import lag_pkg::*;

    // one word in flight: never ready while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted word");

    a_result_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result word repeated");

    a_oor_reads_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("out-of-range result carries a live cell");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind life_automaton_grid_engine lag_port_checker u_lag_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/life_automaton_grid_engine_test.sv =====
// Self-checking bench for life_automaton_grid_engine: a shadow grid predicts every
// result word, then directed and random words are run. Depends on lag_pkg and the RTL.

module life_automaton_grid_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lag_pkg::*;

    localparam int unsigned GRID_ROWS = DEF_MAX_ROWS;
    localparam int unsigned GRID_COLS = DEF_MAX_COLS;
    localparam int unsigned STALL_LIMIT = 100000;

    typedef struct {
        bit cell_value;
        bit out_of_range;
    } cell_result_t;

    class life_grid_shadow;
        bit           cells [GRID_ROWS][GRID_COLS];
        int unsigned  rows_reg;
        int unsigned  cols_reg;
        cell_result_t expected_cells [$];
        int unsigned  mismatches;

        function new();
            rows_reg   = 32'(ACTIVE_ROWS_RST);
            cols_reg   = 32'(ACTIVE_COLS_RST);
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_ACTIVE_ROWS) begin
                rows_reg = 32'(val);
            end else begin
                cols_reg = 32'(val);
            end
        endfunction

        function int unsigned live_rows();
            return (rows_reg > GRID_ROWS) ? GRID_ROWS : rows_reg;
        endfunction

        function int unsigned live_cols();
            return (cols_reg > GRID_COLS) ? GRID_COLS : cols_reg;
        endfunction

        // whole active area from the old generation; cells beyond it count as dead
        function void step_generation();
            bit prev [GRID_ROWS][GRID_COLS];
            int nr;
            int nc;
            int n;
            int rr;
            int cc;
            prev = cells;
            nr = live_rows();
            nc = live_cols();
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
                                n += int'(prev[rr][cc]);
                        end
                    end
                    if (prev[r][c])
                        cells[r][c] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
                    else
                        cells[r][c] = (n == BIRTH_COUNT);
                end
            end
        endfunction

        function void note_word(op_t op, int unsigned row, int unsigned col, bit wv);
            cell_result_t res;
            res.cell_value   = 1'b0;
            res.out_of_range = 1'b0;
            if (op == OP_ADVANCE) begin
                step_generation();
            end else if (row >= live_rows() || col >= live_cols()) begin
                res.out_of_range = 1'b1;
            end else begin
                case (op)
                    OP_WRITE:  cells[row][col] = wv;
                    OP_TOGGLE: cells[row][col] = ~cells[row][col];
                    default: ;
                endcase
                res.cell_value = cells[row][col];
            end
            expected_cells.push_back(res);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] word);
            cell_result_t want;
            if (expected_cells.size() == 0) begin
                $error("result word with no request outstanding: %h", word);
                mismatches++;
                return;
            end
            want = expected_cells.pop_front();
            if (word[0] !== want.cell_value) begin
                $error("cell_value: expected %0d, got %0d", want.cell_value, word[0]);
                mismatches++;
            end
            if (word[1] !== want.out_of_range) begin
                $error("out_of_range: expected %0d, got %0d", want.out_of_range, word[1]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bit              gaps_on = 1'b1;
    int unsigned     stalled_cycles = 0;
    life_grid_shadow grid = new();

    life_automaton_grid_engine u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            grid.check_word(m_tdata);
    end

    // counts cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("life_automaton_grid_engine_test NOT OK");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    task automatic send_word(op_t op, int unsigned row, int unsigned col, bit wv);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, wv, col[6:0], row[6:0], op};
        do @(posedge aclk); while (!s_tready);
        grid.note_word(op, row, col, wv);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (grid.expected_cells.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_size(int unsigned rows_val, int unsigned cols_val);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACTIVE_ROWS;
        cfg_wdata <= rows_val[7:0];
        grid.set_reg(REG_ACTIVE_ROWS, rows_val[7:0]);
        @(negedge aclk);
        cfg_index <= REG_ACTIVE_COLS;
        cfg_wdata <= cols_val[7:0];
        grid.set_reg(REG_ACTIVE_COLS, cols_val[7:0]);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly seeding and stepping patterns inside the active area, some stray accesses
    task automatic random_phase(int unsigned n_words, bit any_size);
        int unsigned rows_val;
        int unsigned cols_val;
        int unsigned er;
        int unsigned ec;
        int unsigned pick;
        int unsigned row;
        int unsigned col;
        bit          costly;
        bit          advanced;
        bit          wv;
        op_t         op;
        if (any_size) begin
            rows_val = $urandom_range(0, 255);
            cols_val = $urandom_range(0, 255);
        end else begin
            rows_val = $urandom_range(1, 12);
            cols_val = $urandom_range(1, 12);
        end
        set_size(rows_val, cols_val);
        er = (rows_val > GRID_ROWS) ? GRID_ROWS : rows_val;
        ec = (cols_val > GRID_COLS) ? GRID_COLS : cols_val;
        costly   = ((er + 1) * (ec + 1) > 400);
        advanced = 1'b0;
        repeat (n_words) begin
            pick = $urandom_range(0, 99);
            row  = (er != 0) ? $urandom_range(0, er - 1) : $urandom_range(0, 127);
            col  = (ec != 0) ? $urandom_range(0, ec - 1) : $urandom_range(0, 127);
            wv   = ($urandom_range(0, 3) != 0);
            if (pick < 10) begin
                op  = op_t'($urandom_range(0, 2));
                row = $urandom_range(0, 127);
                col = $urandom_range(0, 127);
                wv  = 1'($urandom_range(0, 1));
            end else if (pick < 35) begin
                op = OP_WRITE;
            end else if (pick < 45) begin
                op = OP_TOGGLE;
            end else if (pick < 70) begin
                op = OP_READ;
            end else if (costly && advanced) begin
                op = OP_READ;
            end else begin
                op       = OP_ADVANCE;
                advanced = 1'b1;
            end
            send_word(op, row, col, wv);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // sizes from reset: corner cells, far edges, stray accesses
        send_word(OP_READ,   0,   0,   1'b0);
        send_word(OP_WRITE,  0,   0,   1'b1);
        send_word(OP_TOGGLE, 99,  124, 1'b0);
        send_word(OP_READ,   99,  124, 1'b1);
        send_word(OP_WRITE,  127, 127, 1'b1);
        send_word(OP_TOGGLE, 100, 0,   1'b0);
        send_word(OP_READ,   0,   125, 1'b0);
        send_word(OP_WRITE,  0,   1,   1'b1);
        send_word(OP_WRITE,  1,   0,   1'b1);
        send_word(OP_ADVANCE, 127, 127, 1'b1);
        send_word(OP_READ,   1,   1,   1'b0);
        send_word(OP_READ,   99,  124, 1'b0);
        send_word(OP_WRITE,  50,  60,  1'b0);

        // empty grid: everything out of range, advance a no-op
        set_size(0, 125);
        send_word(OP_READ,    0, 0, 1'b0);
        send_word(OP_ADVANCE, 0, 0, 1'b0);
        set_size(255, 0);
        send_word(OP_TOGGLE,  5, 5, 1'b1);

        // full grid, oversized columns clamp; birth in the far corner
        set_size(128, 255);
        send_word(OP_WRITE,   127, 127, 1'b1);
        send_word(OP_WRITE,   127, 126, 1'b1);
        send_word(OP_WRITE,   126, 127, 1'b1);
        send_word(OP_ADVANCE, 0,   0,   1'b0);
        send_word(OP_READ,    126, 126, 1'b0);

        // single cell: its neighbours outside count as dead
        set_size(1, 1);
        send_word(OP_WRITE,   0, 0, 1'b1);
        send_word(OP_ADVANCE, 0, 0, 1'b0);
        send_word(OP_READ,    0, 0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            gaps_on = (p != 4);
            random_phase(10, (p == 2) || (p == 6) || ($urandom_range(0, 5) == 0));
        end
        gaps_on = 1'b1;

        drain();
        repeat (10) @(posedge aclk);
        if (grid.mismatches == 0 && grid.expected_cells.size() == 0) begin
            $display("life_automaton_grid_engine_test OK");
        end else begin
            $display("life_automaton_grid_engine_test NOT OK");
        end
        $finish;
    end

endmodule
